@@ hdl/ufom_pkg.sv @@
package ufom_pkg;

  // queue depths, both powers of two so pointers wrap by truncation
  localparam int TX_DEPTH   = 256;
  localparam int RX_DEPTH   = 64;
  localparam int MARKER_LEN = 16;

  localparam int TX_AW  = $clog2(TX_DEPTH);
  localparam int TX_CW  = $clog2(TX_DEPTH + 1);
  localparam int RX_AW  = $clog2(RX_DEPTH);
  localparam int RX_CW  = $clog2(RX_DEPTH + 1);
  localparam int MARK_W = $clog2(MARKER_LEN);

  localparam int TX_LIMIT_W = 9;
  localparam int RX_LIMIT_W = 7;
  localparam int CFG_W      = 9;

  // common widths for the limit clamps
  localparam int TX_CMP_W = (TX_CW > TX_LIMIT_W) ? TX_CW : TX_LIMIT_W;
  localparam int RX_CMP_W = (RX_CW > RX_LIMIT_W) ? RX_CW : RX_LIMIT_W;

  localparam logic [TX_LIMIT_W-1:0] TX_LIMIT_RESET = TX_LIMIT_W'(256);
  localparam logic [RX_LIMIT_W-1:0] RX_LIMIT_RESET = RX_LIMIT_W'(64);

  // register indexes
  localparam logic CFG_TX_LIMIT = 1'b0;
  localparam logic CFG_RX_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_TX_READY  = 2'd1,
    OP_RX_BYTE   = 2'd2,
    OP_HOST_READ = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_NORMAL     = 2'd0,
    MODE_OVERFLOWED = 2'd1,
    MODE_REJECTED   = 2'd2
  } call_mode_t;

  // cr lf "TX BUFF FULL" cr lf
  function automatic logic [7:0] marker_byte(input logic [MARK_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h0D;
      4'd1:    b = 8'h0A;
      4'd2:    b = 8'h54;
      4'd3:    b = 8'h58;
      4'd4:    b = 8'h20;
      4'd5:    b = 8'h42;
      4'd6:    b = 8'h55;
      4'd7:    b = 8'h46;
      4'd8:    b = 8'h46;
      4'd9:    b = 8'h20;
      4'd10:   b = 8'h46;
      4'd11:   b = 8'h55;
      4'd12:   b = 8'h4C;
      4'd13:   b = 8'h4C;
      4'd14:   b = 8'h0D;
      4'd15:   b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/ufom_ram.sv @@
module ufom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/uart_fifo_with_overflow_marker.sv @@
// transmit and receive byte queues of a uart with a transmit overflow marker. one command
// beat is taken when start is high and busy is low; its result beat appears on the result
// ports for exactly one cycle with done high and must be taken then, the receiver cannot
// stall it. status outputs (tx_full_latched, rx_available, rx_overflow) are valid in the
// done cycle. a receive beat, a host read of an empty receive queue or a transmitter-ready
// beat with nothing queued ends in the exec step; a write byte adds the tail step, a host read
// returning a byte or a transmitter-ready beat handing a byte to the line adds the read data
// step, a write closing a call that hands a byte to the line adds tail and line steps, and one
// triggering the 16-byte warning text adds the marker steps. the single write port and registered
// read of each queue memory shape the steps, the marker text going in one byte a cycle. limits must
// be written through the cfg port only while the block is idle; the block leaves it unenforced.
module uart_fifo_with_overflow_marker (
  input  logic                        clk,
  input  logic                        rst,
  // command beat
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [7:0]                  data,
  input  logic                        first_of_call,
  input  logic                        last_of_call,
  // configuration
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [ufom_pkg::CFG_W-1:0]  cfg_data,
  // result beat
  output logic                        done,
  output logic                        line_valid,
  output logic [7:0]                  line_byte,
  output logic                        read_valid,
  output logic [7:0]                  read_byte,
  output logic                        write_accepted,
  output logic                        tx_full_latched,
  output logic                        rx_available,
  output logic                        rx_overflow
);

  import ufom_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,   // main step of the command
    S_MARK,   // marker text, one byte a cycle
    S_TAIL,   // end of call handling for writes
    S_LINE,   // tx memory read data back, hand to line
    S_RDATA   // rx memory read data back, return to host
  } state_t;

  state_t state;

  // captured command
  op_t        op_q;
  logic [7:0] data_q;
  logic       first_q;
  logic       last_q;

  // queue state
  logic [TX_AW-1:0] tx_rd_ptr;
  logic [TX_CW-1:0] tx_count;
  logic [RX_AW-1:0] rx_rd_ptr;
  logic [RX_CW-1:0] rx_count;
  logic             full_latch;
  call_mode_t       call_mode;
  logic             line_empty;
  logic             rx_dropped;
  logic [MARK_W-1:0] mark_idx;

  logic [TX_LIMIT_W-1:0] tx_limit;
  logic [RX_LIMIT_W-1:0] rx_limit;

  // memory ports
  logic             tx_we;
  logic [TX_AW-1:0] tx_waddr;
  logic [7:0]       tx_wdata;
  logic [7:0]       tx_rdata;
  logic             rx_we;
  logic [RX_AW-1:0] rx_waddr;
  logic [7:0]       rx_rdata;

  // decode
  logic [TX_CMP_W-1:0] tx_lim_eff;
  logic [RX_CMP_W-1:0] rx_lim_eff;
  logic                tx_over;
  logic                tx_room;
  logic                rx_room;
  call_mode_t          mode_eff;
  logic                latch_eff;

  ufom_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .raddr (tx_rd_ptr),
    .rdata (tx_rdata)
  );

  ufom_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (data_q),
    .raddr (rx_rd_ptr),
    .rdata (rx_rdata)
  );

  always_comb begin
    // clamp the limits to their legal ranges
    tx_lim_eff = TX_CMP_W'(tx_limit);
    if (tx_lim_eff < TX_CMP_W'(MARKER_LEN + 1)) begin
      tx_lim_eff = TX_CMP_W'(MARKER_LEN + 1);
    end
    if (tx_lim_eff > TX_CMP_W'(TX_DEPTH)) begin
      tx_lim_eff = TX_CMP_W'(TX_DEPTH);
    end
    rx_lim_eff = RX_CMP_W'(rx_limit);
    if (rx_lim_eff < RX_CMP_W'(1)) begin
      rx_lim_eff = RX_CMP_W'(1);
    end
    if (rx_lim_eff > RX_CMP_W'(RX_DEPTH)) begin
      rx_lim_eff = RX_CMP_W'(RX_DEPTH);
    end

    tx_over = TX_CMP_W'(tx_count) >= (tx_lim_eff - TX_CMP_W'(MARKER_LEN));
    tx_room = tx_count != TX_CW'(TX_DEPTH);
    rx_room = RX_CMP_W'(rx_count) < rx_lim_eff;

    // call mode and latch as seen after the first-of-call decision
    mode_eff  = call_mode;
    latch_eff = full_latch;
    if (first_q) begin
      if (full_latch) begin
        mode_eff = MODE_REJECTED;
        if (tx_count == '0) begin
          latch_eff = 1'b0;
        end
      end else begin
        mode_eff = MODE_NORMAL;
      end
    end

    tx_waddr = tx_rd_ptr + tx_count[TX_AW-1:0];
    rx_waddr = rx_rd_ptr + rx_count[RX_AW-1:0];
    tx_we    = 1'b0;
    tx_wdata = data_q;
    rx_we    = 1'b0;
    case (state)
      S_EXEC: begin
        tx_we = (op_q == OP_WRITE) && (mode_eff == MODE_NORMAL) && !tx_over && tx_room;
        rx_we = (op_q == OP_RX_BYTE) && rx_room;
      end
      S_MARK: begin
        tx_we    = tx_room;
        tx_wdata = marker_byte(mark_idx);
      end
      default: begin
        tx_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      tx_rd_ptr      <= '0;
      tx_count       <= '0;
      rx_rd_ptr      <= '0;
      rx_count       <= '0;
      full_latch     <= 1'b0;
      call_mode      <= MODE_NORMAL;
      line_empty     <= 1'b1;
      rx_dropped     <= 1'b0;
      mark_idx       <= '0;
      tx_limit       <= TX_LIMIT_RESET;
      rx_limit       <= RX_LIMIT_RESET;
      done           <= 1'b0;
      line_valid     <= 1'b0;
      line_byte      <= '0;
      read_valid     <= 1'b0;
      read_byte      <= '0;
      write_accepted <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_write) begin
        case (cfg_index)
          CFG_TX_LIMIT: tx_limit <= cfg_data[TX_LIMIT_W-1:0];
          CFG_RX_LIMIT: rx_limit <= cfg_data[RX_LIMIT_W-1:0];
          default:      tx_limit <= tx_limit;
        endcase
      end

      // pushes always land at the tail
      if (tx_we) begin
        tx_count <= tx_count + TX_CW'(1);
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            op_q           <= op_t'(op);
            data_q         <= data;
            first_q        <= first_of_call;
            last_q         <= last_of_call;
            line_valid     <= 1'b0;
            line_byte      <= '0;
            read_valid     <= 1'b0;
            read_byte      <= '0;
            write_accepted <= 1'b0;
            state          <= S_EXEC;
          end
        end

        S_EXEC: begin
          case (op_q)
            OP_WRITE: begin
              full_latch <= latch_eff;
              call_mode  <= mode_eff;
              state      <= S_TAIL;
              if (mode_eff == MODE_NORMAL) begin
                if (tx_over) begin
                  // queue at warning level: insert the text, drop the rest of the call
                  full_latch <= 1'b1;
                  call_mode  <= MODE_OVERFLOWED;
                  mark_idx   <= '0;
                  state      <= S_MARK;
                end else begin
                  write_accepted <= 1'b1;
                end
              end
            end
            OP_TX_READY: begin
              if (tx_count != '0) begin
                tx_rd_ptr  <= tx_rd_ptr + TX_AW'(1);
                tx_count   <= tx_count - TX_CW'(1);
                line_empty <= 1'b0;
                state      <= S_LINE;
              end else begin
                line_empty <= 1'b1;
                done       <= 1'b1;
                state      <= S_IDLE;
              end
            end
            OP_RX_BYTE: begin
              if (rx_room) begin
                rx_count <= rx_count + RX_CW'(1);
              end else begin
                rx_dropped <= 1'b1;
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
            OP_HOST_READ: begin
              if (rx_count != '0) begin
                rx_rd_ptr <= rx_rd_ptr + RX_AW'(1);
                rx_count  <= rx_count - RX_CW'(1);
                state     <= S_RDATA;
              end else begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end

        S_MARK: begin
          mark_idx <= mark_idx + MARK_W'(1);
          if (mark_idx == MARK_W'(MARKER_LEN - 1)) begin
            state <= S_TAIL;
          end
        end

        S_TAIL: begin
          if (last_q) begin
            call_mode <= MODE_NORMAL;
            if (call_mode != MODE_REJECTED && tx_count != '0 && line_empty) begin
              tx_rd_ptr  <= tx_rd_ptr + TX_AW'(1);
              tx_count   <= tx_count - TX_CW'(1);
              line_empty <= 1'b0;
              state      <= S_LINE;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end

        S_LINE: begin
          line_valid <= 1'b1;
          line_byte  <= tx_rdata;
          done       <= 1'b1;
          state      <= S_IDLE;
        end

        S_RDATA: begin
          read_valid <= 1'b1;
          read_byte  <= rx_rdata;
          done       <= 1'b1;
          state      <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state != S_IDLE);
  assign tx_full_latched = full_latch;
  assign rx_available    = (rx_count != '0);
  assign rx_overflow     = rx_dropped;

  // a result beat only closes a command that was in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a command in progress");

  // one command returns at most one of the two bytes
  a_one_byte: assert property (@(posedge clk) disable iff (rst)
    done |-> !(line_valid && read_valid))
    else $error("line byte and read byte in the same result beat");

  // an accepted command keeps the block busy in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the block busy");

  // queue fills never pass the memory depths
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (tx_count <= TX_CW'(TX_DEPTH)) && (rx_count <= RX_CW'(RX_DEPTH)))
    else $error("queue fill beyond memory depth");

  // the warning text only goes in while the latch is set
  a_mark_latched: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> full_latch)
    else $error("marker insertion without the full latch");

endmodule

@@ tb/sv/uart_fifo_with_overflow_marker_tb.sv @@
module uart_fifo_with_overflow_marker_tb;

  import ufom_pkg::*;

  // run limit in clock cycles, far above the slowest legal run
  localparam int RUN_LIMIT = 200000;
  // cycles to linger after the last beat, above the longest command
  localparam int TAIL_CYCLES = 24;

  // cr lf "TX BUFF FULL" cr lf, first byte in the top octet
  localparam logic [127:0] WARN_TEXT = {8'h0D, 8'h0A, "TX BUFF FULL", 8'h0D, 8'h0A};

  // one result beat, field order matches the port list
  typedef struct packed {
    logic       line_valid;
    logic [7:0] line_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       write_accepted;
    logic       tx_full_latched;
    logic       rx_available;
    logic       rx_overflow;
  } uart_result_t;

  // predicts every result beat from the accepted commands and checks it
  class uart_queue_scoreboard;
    logic [7:0]   line_mem[TX_DEPTH];
    int           line_head;
    int           line_fill;
    logic [7:0]   host_mem[RX_DEPTH];
    int           host_head;
    int           host_fill;
    bit           warn_latched;
    call_mode_t   mode;
    bit           shifter_empty;
    bit           host_lost;
    logic [8:0]   line_cap;
    logic [6:0]   host_cap;
    uart_result_t awaited[$];
    int           errors;

    function new();
      line_head     = 0;
      line_fill     = 0;
      host_head     = 0;
      host_fill     = 0;
      warn_latched  = 1'b0;
      mode          = MODE_NORMAL;
      shifter_empty = 1'b1;
      host_lost     = 1'b0;
      line_cap      = 9'd256;
      host_cap      = 7'd64;
      errors        = 0;
    endfunction

    function void set_limit(logic idx, logic [8:0] value);
      if (idx == CFG_TX_LIMIT) line_cap = value;
      else host_cap = value[6:0];
    endfunction

    function void line_q_push(logic [7:0] b);
      if (line_fill >= TX_DEPTH) return;
      line_mem[(line_head + line_fill) % TX_DEPTH] = b;
      line_fill++;
    endfunction

    function logic [7:0] line_q_pop();
      logic [7:0] b;
      b = line_mem[line_head];
      line_head = (line_head + 1) % TX_DEPTH;
      line_fill--;
      return b;
    endfunction

    function void note_command(op_t kind, logic [7:0] value, logic first, logic last);
      uart_result_t r;
      int tx_cap;
      int rx_cap;
      r = '0;
      tx_cap = (line_cap < MARKER_LEN + 1) ? MARKER_LEN + 1 :
               (line_cap > TX_DEPTH) ? TX_DEPTH : int'(line_cap);
      rx_cap = (host_cap < 1) ? 1 : (host_cap > RX_DEPTH) ? RX_DEPTH : int'(host_cap);
      case (kind)
        OP_WRITE: begin
          if (first) begin
            if (warn_latched) begin
              if (line_fill == 0) warn_latched = 1'b0;
              mode = MODE_REJECTED;
            end else begin
              mode = MODE_NORMAL;
            end
          end
          if (mode == MODE_NORMAL) begin
            if (line_fill >= tx_cap - MARKER_LEN) begin
              for (int i = 0; i < MARKER_LEN; i++) line_q_push(WARN_TEXT[127 - 8 * i -: 8]);
              warn_latched = 1'b1;
              mode = MODE_OVERFLOWED;
            end else begin
              line_q_push(value);
              r.write_accepted = 1'b1;
            end
          end
          if (last) begin
            if (mode != MODE_REJECTED && line_fill != 0 && shifter_empty) begin
              r.line_byte = line_q_pop();
              r.line_valid = 1'b1;
              shifter_empty = 1'b0;
            end
            mode = MODE_NORMAL;
          end
        end
        OP_TX_READY: begin
          if (line_fill != 0) begin
            r.line_byte = line_q_pop();
            r.line_valid = 1'b1;
            shifter_empty = 1'b0;
          end else begin
            shifter_empty = 1'b1;
          end
        end
        OP_RX_BYTE: begin
          if (host_fill < rx_cap) begin
            host_mem[(host_head + host_fill) % RX_DEPTH] = value;
            host_fill++;
          end else begin
            host_lost = 1'b1;
          end
        end
        default: begin
          if (host_fill != 0) begin
            r.read_byte = host_mem[host_head];
            host_head = (host_head + 1) % RX_DEPTH;
            host_fill--;
            r.read_valid = 1'b1;
          end
        end
      endcase
      r.tx_full_latched = warn_latched;
      r.rx_available    = (host_fill != 0);
      r.rx_overflow     = host_lost;
      awaited.push_back(r);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(uart_result_t got);
      uart_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %p", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("line_valid", want.line_valid, got.line_valid);
      compare_field("line_byte", want.line_byte, got.line_byte);
      compare_field("read_valid", want.read_valid, got.read_valid);
      compare_field("read_byte", want.read_byte, got.read_byte);
      compare_field("write_accepted", want.write_accepted, got.write_accepted);
      compare_field("tx_full_latched", want.tx_full_latched, got.tx_full_latched);
      compare_field("rx_available", want.rx_available, got.rx_available);
      compare_field("rx_overflow", want.rx_overflow, got.rx_overflow);
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           op;
  logic [7:0]           data;
  logic                 first_of_call;
  logic                 last_of_call;
  logic                 cfg_write;
  logic                 cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 done;
  logic                 line_valid;
  logic [7:0]           line_byte;
  logic                 read_valid;
  logic [7:0]           read_byte;
  logic                 write_accepted;
  logic                 tx_full_latched;
  logic                 rx_available;
  logic                 rx_overflow;

  uart_result_t         seen;
  uart_queue_scoreboard board;
  int                   cycles;

  uart_fifo_with_overflow_marker u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .data            (data),
    .first_of_call   (first_of_call),
    .last_of_call    (last_of_call),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .line_valid      (line_valid),
    .line_byte       (line_byte),
    .read_valid      (read_valid),
    .read_byte       (read_byte),
    .write_accepted  (write_accepted),
    .tx_full_latched (tx_full_latched),
    .rx_available    (rx_available),
    .rx_overflow     (rx_overflow)
  );

  // clock, period 8
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // result beats are gathered into one struct for the scoreboard
  assign seen = {line_valid, line_byte, read_valid, read_byte, write_accepted,
                 tx_full_latched, rx_available, rx_overflow};

  // result monitor: a done beat can never be held off, so every one is taken
  always @(posedge clk) begin
    if (!rst && done) board.check_result(seen);
  end

  // offer one command beat from the falling edge and hold it until taken
  task automatic send_beat(op_t kind, logic [7:0] value, logic first, logic last);
    @(negedge clk);
    start         = 1'b1;
    op            = kind;
    data          = value;
    first_of_call = first;
    last_of_call  = last;
    // busy is read just after the edge, i.e. its value before the edge
    do @(posedge clk); while (busy);
    board.note_command(kind, value, first, last);
  endtask

  // sender goes quiet for a burst of cycles
  task automatic idle_burst(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // sender holds back until every result is in and the block is idle
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (board.outstanding() != 0 || busy) @(posedge clk);
  endtask

  // register write, only ever issued while the block is idle
  task automatic write_limit(logic idx, logic [8:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    board.set_limit(idx, value);
  endtask

  task automatic maybe_idle(int idle_pct);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) idle_burst($urandom_range(1, 16));
  endtask

  // random traffic: mostly well-formed write calls, the rest drain, line input, host
  // reads and noise with stray call marks; drain_pct sets how hard the line is pulled
  task automatic random_phase(int beats, int idle_pct, int drain_pct);
    int sent;
    int pick;
    int len;
    int b_call;
    int b_ready;
    int b_rx;
    int b_read;
    sent    = 0;
    b_call  = 45;
    b_ready = b_call + drain_pct;
    b_rx    = b_ready + (100 - b_ready) * 2 / 5;
    b_read  = b_rx + (100 - b_ready) * 2 / 5;
    while (sent < beats) begin
      pick = $urandom_range(0, 99);
      if (pick < b_call) begin
        // whole call with random content
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          send_beat(OP_WRITE, 8'($urandom_range(0, 255)), k == 0, k == len - 1);
          maybe_idle(idle_pct);
        end
        sent += len;
      end else begin
        if (pick < b_ready)
          send_beat(OP_TX_READY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else if (pick < b_rx)
          send_beat(OP_RX_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else if (pick < b_read)
          send_beat(OP_HOST_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else
          // stray write beat: call marks at random, may split or restart a call
          send_beat(OP_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        maybe_idle(idle_pct);
        sent++;
      end
    end
  endtask

  // new limits between phases; the queues keep whatever they still hold
  task automatic run_phase(logic [8:0] tx_lim, logic [8:0] rx_lim, int beats, int idle_pct,
                           int drain_pct);
    drain_results();
    write_limit(CFG_TX_LIMIT, tx_lim);
    write_limit(CFG_RX_LIMIT, rx_lim);
    random_phase(beats, idle_pct, drain_pct);
  endtask

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    board         = new();
    rst           = 1'b1;
    start         = 1'b0;
    op            = OP_WRITE;
    data          = 8'h00;
    first_of_call = 1'b0;
    last_of_call  = 1'b0;
    cfg_write     = 1'b0;
    cfg_index     = CFG_TX_LIMIT;
    cfg_data      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: tightest limits so the warning and receive overflow come at once
    write_limit(CFG_TX_LIMIT, 9'd17);
    write_limit(CFG_RX_LIMIT, 9'd1);
    send_beat(OP_TX_READY, 8'hFF, 1'b1, 1'b1);   // nothing queued, line marked idle
    send_beat(OP_HOST_READ, 8'hFF, 1'b1, 1'b1);  // empty receive queue
    send_beat(OP_RX_BYTE, 8'hFF, 1'b0, 1'b0);
    send_beat(OP_RX_BYTE, 8'h00, 1'b1, 1'b1);    // queue full, dropped and flagged
    send_beat(OP_HOST_READ, 8'h00, 1'b0, 1'b0);
    send_beat(OP_WRITE, 8'hFF, 1'b0, 1'b0);      // write outside a call, still taken
    send_beat(OP_WRITE, 8'h00, 1'b1, 1'b0);      // new call mid-call, hits the warning
    send_beat(OP_WRITE, 8'hAA, 1'b0, 1'b1);      // dropped, end of call feeds the line
    send_beat(OP_WRITE, 8'h55, 1'b1, 1'b1);      // latched: whole call refused
    send_beat(OP_TX_READY, 8'h00, 1'b0, 1'b0);
    send_beat(OP_HOST_READ, 8'h5A, 1'b0, 1'b1);

    // random phases over the limit range, out-of-range values clamp
    run_phase(9'd17, 9'd1, 70, 30, 15);
    run_phase(9'd64, 9'd64, 80, 20, 5);
    run_phase(9'd0, 9'd0, 70, 0, 25);
    run_phase(9'd511, 9'd127, 70, 40, 10);
    run_phase(9'd40, 9'd5, 80, 25, 15);
    // last stretch runs flat out
    run_phase(9'd256, 9'd33, 80, 0, 20);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
